// File: sv/prt_pkg.sv
// Shared constants and types for the percentile rank tracker.
// Used by prt_ctrl, prt_datapath, prt_div and percentile_rank_tracker.
// No dependencies.
package prt_pkg;

    localparam int USER_SLOTS_DEF    = 131072;
    localparam int PAGE_SLOTS_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 20;

    localparam int USER_W = 17;
    localparam int PAGE_W = 10;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ONE,
        RES_QUOT
    } res_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     clr_step;
        logic     capture;
        logic     prog_rd;
        logic     hist_rd_old;
        logic     hist_dec;
        logic     hist_rd_new;
        logic     rec_write;
        logic     scan_start;
        logic     scan_issue;
        logic     div_start;
        logic     res_load;
        res_sel_t res_sel;
    } prt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic rec_ok;
        logic user_ok;
        logic mine_valid;
        logic mine_is_one;
        logic sole;
        logic scan_last;
        logic div_done;
    } prt_stat_t;

endpackage

// File: sv/prt_div.sv
// Restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit a cycle.
// Dividend never exceeds divisor, so the quotient fits FRACTION_BITS + 1 bits.
// Depends on prt_pkg.
module prt_div #(
    parameter int CNT_W         = 18,
    parameter int FRACTION_BITS = prt_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CNT_W-1:0]         dividend,
    input  logic [CNT_W-1:0]         divisor,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quotient
);
    import prt_pkg::*;

    localparam int Q_W    = FRACTION_BITS + 1;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W:0]      rem_reg, rem_next;
    logic [Q_W-1:0]      quo_reg, quo_next;

    logic [CNT_W:0]      dvs_ext;
    logic                ge;
    logic [CNT_W:0]      trial;

    assign dvs_ext = {1'b0, divisor};
    assign ge      = rem_reg >= dvs_ext;
    assign trial   = ge ? (rem_reg - dvs_ext) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, dividend};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so the shift cannot overflow
            quo_next  = {quo_reg[Q_W-2:0], ge};
            rem_next  = {trial[CNT_W-1:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(FRACTION_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (quo_reg <= (Q_W'(1) << FRACTION_BITS)))
        else $error("quotient above one");

endmodule

// File: sv/prt_datapath.sv
// Datapath: progress and histogram memories, reader count, prefix-sum scan,
// result register and the divider. Driven by prt_ctrl.
// Depends on prt_pkg and prt_div.
module prt_datapath #(
    parameter int USER_SLOTS    = prt_pkg::USER_SLOTS_DEF,
    parameter int PAGE_SLOTS    = prt_pkg::PAGE_SLOTS_DEF,
    parameter int FRACTION_BITS = prt_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  prt_pkg::prt_cmd_t            ctl,
    output prt_pkg::prt_stat_t           stat,
    input  logic                         cmd,
    input  logic [prt_pkg::USER_W-1:0]   user_id,
    input  logic [prt_pkg::PAGE_W-1:0]   page,
    output logic [FRACTION_BITS:0]       share
);
    import prt_pkg::*;

    localparam int PROG_AW = $clog2(USER_SLOTS);
    localparam int HIST_AW = $clog2(PAGE_SLOTS);
    localparam int CNT_W   = $clog2(USER_SLOTS + 1);
    localparam int CLR_N   = (USER_SLOTS > PAGE_SLOTS) ? USER_SLOTS : PAGE_SLOTS;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int Q_W     = FRACTION_BITS + 1;

    logic [PAGE_W-1:0] prog_mem [USER_SLOTS];
    logic [CNT_W-1:0]  hist_mem [PAGE_SLOTS];

    logic              cmd_reg;
    logic [USER_W-1:0] user_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] prog_q_reg;
    logic [CNT_W-1:0]  hist_q_reg;
    logic [CNT_W-1:0]  reader_reg, reader_next;
    logic [CLR_W-1:0]  clr_reg;
    logic [PAGE_W-1:0] scan_p_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic              pend_reg;
    logic [Q_W-1:0]    share_reg;

    logic              old_zero;
    logic              dec_en;
    logic              prog_we;
    logic [PROG_AW-1:0] prog_wa;
    logic [PAGE_W-1:0] prog_wd;
    logic              hist_we;
    logic [HIST_AW-1:0] hist_wa;
    logic [CNT_W-1:0]  hist_wd;
    logic              hist_re;
    logic [HIST_AW-1:0] hist_ra;
    logic              page_ok;
    logic              div_done;
    logic [Q_W-1:0]    quotient;

    assign old_zero = prog_q_reg == '0;
    assign dec_en   = ctl.hist_dec && !old_zero && (32'(prog_q_reg) < PAGE_SLOTS)
                      && (hist_q_reg != '0);

    always_comb
    begin
        prog_we = 1'b0;
        prog_wa = PROG_AW'(user_reg);
        prog_wd = page_reg;
        priority if (ctl.clr_step)
        begin
            prog_we = 32'(clr_reg) < USER_SLOTS;
            prog_wa = PROG_AW'(clr_reg);
            prog_wd = '0;
        end
        else if (ctl.rec_write)
        begin
            prog_we = 1'b1;
        end
    end

    always_comb
    begin
        hist_we = 1'b0;
        hist_wa = HIST_AW'(page_reg);
        hist_wd = hist_q_reg + CNT_W'(1);
        priority if (ctl.clr_step)
        begin
            hist_we = 32'(clr_reg) < PAGE_SLOTS;
            hist_wa = HIST_AW'(clr_reg);
            hist_wd = '0;
        end
        else if (dec_en)
        begin
            hist_we = 1'b1;
            hist_wa = HIST_AW'(prog_q_reg);
            hist_wd = hist_q_reg - CNT_W'(1);
        end
        else if (ctl.rec_write)
        begin
            hist_we = 1'b1;
        end
    end

    always_comb
    begin
        hist_re = ctl.hist_rd_old || ctl.hist_rd_new || ctl.scan_issue;
        priority if (ctl.hist_rd_old)
            hist_ra = HIST_AW'(prog_q_reg);
        else if (ctl.hist_rd_new)
            hist_ra = HIST_AW'(page_reg);
        else
            hist_ra = HIST_AW'(scan_p_reg);
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
            prog_mem[prog_wa] <= prog_wd;
        if (ctl.prog_rd)
            prog_q_reg <= prog_mem[PROG_AW'(user_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        if (hist_re)
            hist_q_reg <= hist_mem[hist_ra];
    end

    always_comb
    begin
        reader_next = reader_reg;
        if (ctl.hist_dec && old_zero)
            reader_next = reader_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reader_reg <= '0;
            clr_reg    <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            reader_reg <= reader_next;
            if (ctl.clr_step)
                clr_reg <= clr_reg + CLR_W'(1);
            pend_reg <= ctl.scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            user_reg <= user_id;
            page_reg <= page;
        end
        if (ctl.scan_start)
        begin
            scan_p_reg <= PAGE_W'(1);
            acc_reg    <= '0;
        end
        else
        begin
            if (ctl.scan_issue)
                scan_p_reg <= scan_p_reg + PAGE_W'(1);
            // read data arrives in the cycle after its address is issued
            if (pend_reg)
                acc_reg <= acc_reg + hist_q_reg;
        end
        if (ctl.res_load)
        begin
            unique case (ctl.res_sel)
                RES_ZERO: share_reg <= '0;
                RES_ONE:  share_reg <= Q_W'(1) << FRACTION_BITS;
                RES_QUOT: share_reg <= quotient;
                default:  share_reg <= '0;
            endcase
        end
    end

    prt_div #(
        .CNT_W         (CNT_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (acc_reg),
        .divisor  (reader_reg - CNT_W'(1)),
        .done     (div_done),
        .quotient (quotient)
    );

    assign page_ok = (page_reg != '0) && (32'(page_reg) < PAGE_SLOTS);

    always_comb
    begin
        stat.clr_last    = clr_reg == CLR_W'(CLR_N - 1);
        stat.is_query    = cmd_reg == CMD_QUERY;
        stat.user_ok     = 32'(user_reg) < USER_SLOTS;
        stat.rec_ok      = stat.user_ok && page_ok;
        stat.mine_valid  = !old_zero && (32'(prog_q_reg) < PAGE_SLOTS);
        stat.mine_is_one = prog_q_reg == PAGE_W'(1);
        stat.sole        = reader_reg <= CNT_W'(1);
        stat.scan_last   = scan_p_reg == (prog_q_reg - PAGE_W'(1));
        stat.div_done    = div_done;
    end

    assign share = share_reg;

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_issue |-> (scan_p_reg != '0) && (scan_p_reg < prog_q_reg))
        else $error("scan read outside lower pages");

    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ({1'b0, acc_reg} + {1'b0, hist_q_reg} <= {1'b0, reader_reg}))
        else $error("lower-page count exceeds readers");

endmodule

// File: sv/prt_ctrl.sv
// Controller state machine: clearing pass, record and query sequences,
// result beat handshake. Depends on prt_pkg.
module prt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  prt_pkg::prt_stat_t  stat,
    output prt_pkg::prt_cmd_t   ctl
);
    import prt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PROG_RD,
        S_ROUTE,
        S_REC_DEC,
        S_REC_RDNEW,
        S_REC_INC,
        S_SCAN,
        S_SCAN_END,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t   state_reg, state_next;
    logic     out_valid_reg, out_valid_next;
    res_sel_t res_sel_reg, res_sel_next;

    always_comb
    begin
        ctl            = '0;
        ctl.res_sel    = res_sel_reg;
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_PROG_RD;
                end
            end
            S_PROG_RD:
            begin
                ctl.prog_rd = 1'b1;
                state_next  = S_ROUTE;
            end
            S_ROUTE:
            begin
                if (!stat.is_query)
                begin
                    if (stat.rec_ok)
                    begin
                        ctl.hist_rd_old = 1'b1;
                        state_next      = S_REC_DEC;
                    end
                    else
                        state_next = S_IDLE;
                end
                else if (!stat.user_ok || !stat.mine_valid)
                begin
                    res_sel_next = RES_ZERO;
                    state_next   = S_OUT;
                end
                else if (stat.sole)
                begin
                    res_sel_next = RES_ONE;
                    state_next   = S_OUT;
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = stat.mine_is_one ? S_DIV_GO : S_SCAN;
                end
            end
            S_REC_DEC:
            begin
                ctl.hist_dec = 1'b1;
                state_next   = S_REC_RDNEW;
            end
            S_REC_RDNEW:
            begin
                ctl.hist_rd_new = 1'b1;
                state_next      = S_REC_INC;
            end
            S_REC_INC:
            begin
                ctl.rec_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (stat.scan_last)
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
                state_next = S_DIV_GO;
            S_DIV_GO:
            begin
                ctl.div_start = 1'b1;
                res_sel_next  = RES_QUOT;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the result until the previous beat has gone
                if (!out_valid_reg || out_ready)
                begin
                    ctl.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            res_sel_reg   <= RES_ZERO;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_sel_reg   <= res_sel_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    a_div_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load && (res_sel_reg == RES_QUOT) |-> $past(state_reg) == S_DIV_WAIT
            || $past(state_reg) == S_OUT)
        else $error("quotient loaded before division ended");

endmodule

// File: sv/percentile_rank_tracker.sv
// Top level of the percentile rank tracker: controller plus datapath.
// Depends on prt_pkg, prt_ctrl, prt_datapath (and prt_div below it).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  input   | in        | in_valid / in_ready  | cmd, user_id, page
//  result  | out       | out_valid / out_ready| share (one beat per query)
//
// After reset a clearing pass writes every progress and histogram entry across
// max(USER_SLOTS, PAGE_SLOTS) addresses (131072 at defaults); no beat is taken.
// A record does a progress read, histogram read-modify-write twice, progress write.
// A query that needs a division sums the lower pages through the single
// histogram read port, one page per cycle, then the divider gives one
// quotient bit per cycle.
// One item at a time; a finished result waits in the output register while
// the next item is accepted, and a query stalls only if that beat is still held.
module percentile_rank_tracker #(
    parameter int USER_SLOTS    = prt_pkg::USER_SLOTS_DEF,
    parameter int PAGE_SLOTS    = prt_pkg::PAGE_SLOTS_DEF,
    parameter int FRACTION_BITS = prt_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [prt_pkg::USER_W-1:0]   user_id,
    input  logic [prt_pkg::PAGE_W-1:0]   page,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FRACTION_BITS:0]       share
);
    import prt_pkg::*;

    prt_cmd_t  ctl;
    prt_stat_t stat;

    prt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    prt_datapath #(
        .USER_SLOTS    (USER_SLOTS),
        .PAGE_SLOTS    (PAGE_SLOTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .stat    (stat),
        .cmd     (cmd),
        .user_id (user_id),
        .page    (page),
        .share   (share)
    );

endmodule
